/* hw/rtl/assert_macros.svh */
// Assertion shorthands shared by the checker files.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfq check failed");

// Consequent must hold in the cycle after the antecedent.
`define MFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfq check failed");

`endif

/* hw/rtl/mfq_pkg.sv */
package mfq_pkg;

  localparam int MAX_LEVELS_DEF = 8;
  localparam int MAX_PROCS_DEF  = 16;

  localparam int PID_W     = 8;
  localparam int LEVEL_W   = 4;
  localparam int NUMLVL_W  = 4;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 3;

  localparam logic [NUMLVL_W-1:0] NUM_LEVELS_RST   = 4'd4;
  localparam logic [PERIOD_W-1:0] BOOST_PERIOD_RST = 16'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PERIOD = 1'd1;

  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_SLICE = 1'b1;

  typedef enum logic [1:0] {
    OUT_YIELD   = 2'd0,
    OUT_FULL    = 2'd1,
    OUT_FINISH  = 2'd2,
    OUT_INVALID = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    KIND_YIELD = 3'd0,
    KIND_FULL  = 3'd1,
    KIND_EXIT  = 3'd2,
    KIND_BOOST = 3'd3,
    KIND_ADMIT = 3'd4,
    KIND_ERROR = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_BREAD,
    ST_BMOVE
  } state_t;

  // Pointer and occupancy updates for one cycle.
  typedef struct packed {
    logic               pop;
    logic [LEVEL_W-1:0] pop_lv;
    logic               push;
    logic [LEVEL_W-1:0] push_lv;
    logic               tot_inc;
    logic               tot_dec;
  } qtab_upd_t;

endpackage

/* hw/rtl/multilevel_feedback_queue_scheduler_unit.sv */
// Channel  | Direction | Transfer on            | Payload
// ---------+-----------+------------------------+------------------------------------------
// in_      | input     | in_tvalid & in_tready  | tuser: func; tdata: proc_id, outcome
// out_     | output    | out_tvalid & out_tready| tuser: kind; tdata: proc_id, level; tlast
// cfg_     | input     | cfg_we                 | cfg_index selects register, cfg_wdata
//
// An admit goes from the decide step back to idle; a slice goes on to the read step,
// unless no level in use holds a process. Each boost move is a read state then a write
// state, set by the read-then-write of the single queue RAM.
// Reset (rst_n, synchronous) clears pointers, occupancies and the slice counter; the
// queue RAM is not cleared, as only entries the pointers mark as occupied are read.
// A result waits in the output register while out_tready is low; the decide, read and
// boost-move steps each wait until that register is free.
module multilevel_feedback_queue_scheduler_unit #(
  parameter int MAX_LEVELS = mfq_pkg::MAX_LEVELS_DEF,
  parameter int MAX_PROCS  = mfq_pkg::MAX_PROCS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mfq_pkg::IN_TDATA_W-1:0]      in_tdata,   // proc_id[7:0], outcome[9:8]
  input  logic [0:0]                          in_tuser,   // func[0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mfq_pkg::OUT_TDATA_W-1:0]     out_tdata,  // proc_id[7:0], level[11:8]
  output logic [mfq_pkg::OUT_TUSER_W-1:0]     out_tuser,  // kind[2:0]
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [mfq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SW  = $clog2(MAX_PROCS);
  localparam int AW  = LVW + SW;
  localparam int LW  = mfq_pkg::LEVEL_W;
  localparam int PW  = mfq_pkg::PID_W;

  // Configuration registers.
  logic [mfq_pkg::NUMLVL_W-1:0] num_levels_r;
  logic [mfq_pkg::PERIOD_W-1:0] boost_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r   <= mfq_pkg::NUM_LEVELS_RST;
      boost_period_r <= mfq_pkg::BOOST_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfq_pkg::CFG_NUM_LEVELS:   num_levels_r   <= cfg_wdata[mfq_pkg::NUMLVL_W-1:0];
        mfq_pkg::CFG_BOOST_PERIOD: boost_period_r <= cfg_wdata[mfq_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and item registers.
  mfq_pkg::state_t   state_r, state_nxt;
  logic              func_r;
  logic [PW-1:0]     pid_r;
  mfq_pkg::outcome_t outcome_r;
  logic [LW-1:0]     lv_r;
  logic [mfq_pkg::PERIOD_W-1:0] cnt_r;

  // Output register.
  logic              out_tvalid_r;
  mfq_pkg::kind_t    out_kind_r, out_kind_nxt;
  logic [PW-1:0]     out_pid_r, out_pid_nxt;
  logic [LW-1:0]     out_level_r, out_level_nxt;
  logic              out_last_r, out_last_nxt;
  logic              emit;
  logic              out_free;

  // Queue table and RAM.
  mfq_pkg::qtab_upd_t upd;
  logic [LW-1:0]      hd_lv, tl_lv;
  logic [SW-1:0]      head_slot, tail_slot;
  logic [MAX_LEVELS-1:0] nonempty, nonempty_nxt;
  logic               full;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [PW-1:0]      ram_wdata, ram_rdata;

  // Decision logic.
  logic [LW-1:0]      nl, top_lv, slice_lv, bsrc_lv, dst_lv;
  logic               slice_found, lower_any_nxt, boost_hit;
  logic [mfq_pkg::PERIOD_W-1:0] cnt_inc;
  logic               lv_ld, cnt_ld;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    nl = num_levels_r;
    if (num_levels_r == '0) begin
      nl = LW'(1);
    end else if (32'(num_levels_r) > MAX_LEVELS) begin
      nl = LW'(MAX_LEVELS);
    end
    top_lv = nl - LW'(1);
    slice_found   = 1'b0;
    slice_lv      = '0;
    bsrc_lv       = '0;
    lower_any_nxt = 1'b0;
    // Later hits override earlier ones, so each search ends on the highest level.
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (nonempty[i] && (LW'(i) < nl)) begin
        slice_found = 1'b1;
        slice_lv    = LW'(i);
      end
      if (nonempty[i] && (LW'(i) < top_lv)) begin
        bsrc_lv = LW'(i);
      end
      if (nonempty_nxt[i] && (LW'(i) < top_lv)) begin
        lower_any_nxt = 1'b1;
      end
    end
    case (outcome_r)
      mfq_pkg::OUT_FULL: dst_lv = (lv_r != '0) ? lv_r - LW'(1) : '0;
      default:           dst_lv = lv_r;
    endcase
    cnt_inc   = cnt_r + 1'b1;
    boost_hit = (cnt_inc == boost_period_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfq_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = mfq_pkg::ST_DECIDE;
        end
      end
      mfq_pkg::ST_DECIDE: begin
        if (out_free) begin
          if (func_r == mfq_pkg::FUNC_ADMIT || !slice_found) begin
            state_nxt = mfq_pkg::ST_IDLE;
          end else begin
            state_nxt = mfq_pkg::ST_READ;
          end
        end
      end
      mfq_pkg::ST_READ: begin
        if (out_free) begin
          if (outcome_r != mfq_pkg::OUT_INVALID && boost_hit && lower_any_nxt) begin
            state_nxt = mfq_pkg::ST_BREAD;
          end else begin
            state_nxt = mfq_pkg::ST_IDLE;
          end
        end
      end
      mfq_pkg::ST_BREAD: begin
        state_nxt = mfq_pkg::ST_BMOVE;
      end
      mfq_pkg::ST_BMOVE: begin
        if (out_free) begin
          state_nxt = lower_any_nxt ? mfq_pkg::ST_BREAD : mfq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mfq_pkg::ST_IDLE;
    endcase
  end

  // State outputs. Reads and writes of the RAM never fall in the same cycle, and a
  // write always lands in the RAM before any read of the same entry.
  always_comb begin
    in_tready     = 1'b0;
    upd           = '0;
    hd_lv         = '0;
    tl_lv         = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    emit          = 1'b0;
    out_kind_nxt  = mfq_pkg::KIND_ERROR;
    out_pid_nxt   = '0;
    out_level_nxt = '0;
    out_last_nxt  = 1'b1;
    lv_ld         = 1'b0;
    cnt_ld        = 1'b0;
    case (state_r)
      mfq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      mfq_pkg::ST_DECIDE: begin
        hd_lv = slice_lv;
        tl_lv = top_lv;
        if (out_free) begin
          if (func_r == mfq_pkg::FUNC_ADMIT) begin
            emit        = 1'b1;
            out_pid_nxt = pid_r;
            if (!full) begin
              ram_we        = 1'b1;
              ram_waddr     = {top_lv[LVW-1:0], tail_slot};
              ram_wdata     = pid_r;
              upd.push      = 1'b1;
              upd.push_lv   = top_lv;
              upd.tot_inc   = 1'b1;
              out_kind_nxt  = mfq_pkg::KIND_ADMIT;
              out_level_nxt = nl;
            end
          end else if (!slice_found) begin
            emit = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = {slice_lv[LVW-1:0], head_slot};
            lv_ld     = 1'b1;
          end
        end
      end
      mfq_pkg::ST_READ: begin
        hd_lv = lv_r;
        tl_lv = dst_lv;
        if (out_free) begin
          emit        = 1'b1;
          out_pid_nxt = ram_rdata;
          if (outcome_r != mfq_pkg::OUT_INVALID) begin
            upd.pop    = 1'b1;
            upd.pop_lv = lv_r;
            cnt_ld     = 1'b1;
            if (outcome_r == mfq_pkg::OUT_FINISH) begin
              upd.tot_dec  = 1'b1;
              out_kind_nxt = mfq_pkg::KIND_EXIT;
            end else begin
              ram_we        = 1'b1;
              ram_waddr     = {dst_lv[LVW-1:0], tail_slot};
              ram_wdata     = ram_rdata;
              upd.push      = 1'b1;
              upd.push_lv   = dst_lv;
              out_level_nxt = dst_lv + LW'(1);
              out_kind_nxt  = (outcome_r == mfq_pkg::OUT_YIELD) ? mfq_pkg::KIND_YIELD
                                                                 : mfq_pkg::KIND_FULL;
            end
            out_last_nxt = !(boost_hit && lower_any_nxt);
          end
        end
      end
      mfq_pkg::ST_BREAD: begin
        hd_lv      = bsrc_lv;
        ram_re     = 1'b1;
        ram_raddr  = {bsrc_lv[LVW-1:0], head_slot};
        upd.pop    = 1'b1;
        upd.pop_lv = bsrc_lv;
      end
      mfq_pkg::ST_BMOVE: begin
        tl_lv = top_lv;
        if (out_free) begin
          ram_we        = 1'b1;
          ram_waddr     = {top_lv[LVW-1:0], tail_slot};
          ram_wdata     = ram_rdata;
          upd.push      = 1'b1;
          upd.push_lv   = top_lv;
          emit          = 1'b1;
          out_kind_nxt  = mfq_pkg::KIND_BOOST;
          out_pid_nxt   = ram_rdata;
          out_level_nxt = nl;
          out_last_nxt  = !lower_any_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mfq_pkg::ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cnt_ld) begin
        cnt_r <= boost_hit ? '0 : cnt_inc;
      end
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r    <= in_tuser[0];
      pid_r     <= in_tdata[PW-1:0];
      outcome_r <= mfq_pkg::outcome_t'(in_tdata[PW+1:PW]);
    end
    if (lv_ld) begin
      lv_r <= slice_lv;
    end
    if (emit) begin
      out_kind_r  <= out_kind_nxt;
      out_pid_r   <= out_pid_nxt;
      out_level_r <= out_level_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(mfq_pkg::OUT_TDATA_W - PW - LW)'(0), out_level_r, out_pid_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  mfq_qtab #(
    .MAX_LEVELS(MAX_LEVELS),
    .MAX_PROCS (MAX_PROCS)
  ) u_qtab (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (upd),
    .hd_lv       (hd_lv),
    .tl_lv       (tl_lv),
    .head_slot   (head_slot),
    .tail_slot   (tail_slot),
    .nonempty    (nonempty),
    .nonempty_nxt(nonempty_nxt),
    .full        (full)
  );

  mfq_ram #(
    .WIDTH(PW),
    .DEPTH(1 << AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

/* hw/rtl/mfq_ram.sv */
module mfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mfq_qtab.sv */
module mfq_qtab #(
  parameter int MAX_LEVELS = mfq_pkg::MAX_LEVELS_DEF,
  parameter int MAX_PROCS  = mfq_pkg::MAX_PROCS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mfq_pkg::qtab_upd_t            upd,
  input  logic [mfq_pkg::LEVEL_W-1:0]   hd_lv,
  input  logic [mfq_pkg::LEVEL_W-1:0]   tl_lv,
  output logic [$clog2(MAX_PROCS)-1:0]  head_slot,
  output logic [$clog2(MAX_PROCS)-1:0]  tail_slot,
  output logic [MAX_LEVELS-1:0]         nonempty,
  output logic [MAX_LEVELS-1:0]         nonempty_nxt,
  output logic                          full
);

  localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SW  = $clog2(MAX_PROCS);
  localparam int OW  = $clog2(MAX_PROCS + 1);

  logic [SW-1:0] head_r   [MAX_LEVELS];
  logic [SW-1:0] head_nxt [MAX_LEVELS];
  logic [SW-1:0] tail_r   [MAX_LEVELS];
  logic [SW-1:0] tail_nxt [MAX_LEVELS];
  logic [OW-1:0] occ_r    [MAX_LEVELS];
  logic [OW-1:0] occ_nxt  [MAX_LEVELS];
  logic [OW-1:0] total_r;
  logic [OW-1:0] total_nxt;

  function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
    ptr_inc = (p == SW'(MAX_PROCS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    logic pop_hit;
    logic push_hit;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      pop_hit  = upd.pop  && (upd.pop_lv  == mfq_pkg::LEVEL_W'(i));
      push_hit = upd.push && (upd.push_lv == mfq_pkg::LEVEL_W'(i));
      head_nxt[i] = pop_hit  ? ptr_inc(head_r[i]) : head_r[i];
      tail_nxt[i] = push_hit ? ptr_inc(tail_r[i]) : tail_r[i];
      occ_nxt[i]  = occ_r[i] + OW'(push_hit) - OW'(pop_hit);
      nonempty[i]     = (occ_r[i] != '0);
      nonempty_nxt[i] = (occ_nxt[i] != '0);
    end
    total_nxt = total_r + OW'(upd.tot_inc) - OW'(upd.tot_dec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        occ_r[i]  <= '0;
      end
      total_r <= '0;
    end else begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        occ_r[i]  <= occ_nxt[i];
      end
      total_r <= total_nxt;
    end
  end

  assign head_slot = head_r[hd_lv[LVW-1:0]];
  assign tail_slot = tail_r[tl_lv[LVW-1:0]];
  assign full      = (total_r == OW'(MAX_PROCS));

endmodule

/* hw/rtl/mfq_checker.sv */
`include "assert_macros.svh"

module mfq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mfq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [mfq_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input logic                              out_tlast
);

  // A result not yet taken keeps its contents.
  `MFQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // While a boost run is still being delivered, no new item is taken.
  `MFQ_ASSERT_NOW(a_busy_mid_run, out_tvalid && !out_tlast, !in_tready)

  // The cycle after a transfer in, the block is working on it.
  `MFQ_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready)

  // Exits and errors leave the process in no level.
  `MFQ_ASSERT_NOW(a_no_level, out_tvalid && (out_tuser == mfq_pkg::KIND_EXIT || out_tuser == mfq_pkg::KIND_ERROR), out_tdata[11:8] == 4'd0)

  // Admits and errors are always the only result of their item.
  `MFQ_ASSERT_NOW(a_single, out_tvalid && (out_tuser == mfq_pkg::KIND_ADMIT || out_tuser == mfq_pkg::KIND_ERROR), out_tlast)

endmodule

bind multilevel_feedback_queue_scheduler_unit mfq_checker u_mfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

/* bench/testbench.sv */
module testbench;

  localparam int MAX_LV = mfq_pkg::MAX_LEVELS_DEF;
  localparam int MAX_PR = mfq_pkg::MAX_PROCS_DEF;

  typedef struct {
    logic              func;
    logic [7:0]        pid;
    mfq_pkg::outcome_t oc;
  } sched_req_t;

  typedef struct {
    mfq_pkg::kind_t kind;
    logic [7:0]     pid;
    logic [3:0]     level;
    logic           last;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [mfq_pkg::IN_TDATA_W-1:0]   in_tdata = '0;   // proc_id[7:0], outcome[9:8]
  logic [0:0]                       in_tuser = '0;   // func[0]
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [mfq_pkg::OUT_TDATA_W-1:0]  out_tdata;       // proc_id[7:0], level[11:8]
  logic [mfq_pkg::OUT_TUSER_W-1:0]  out_tuser;       // kind[2:0]
  logic                             out_tlast;
  logic                             cfg_we = 1'b0;
  logic [mfq_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [mfq_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  multilevel_feedback_queue_scheduler_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor copy of the scheduler state and its registers.
  logic [7:0]  run_queue [MAX_LV][MAX_PR];
  logic [3:0]  q_head [MAX_LV];
  logic [3:0]  q_tail [MAX_LV];
  logic [4:0]  q_occ [MAX_LV];
  logic [4:0]  total_procs;
  logic [15:0] slices_since_boost;
  logic [3:0]  levels_reg;
  logic [15:0] period_reg;

  sched_req_t    pending_reqs[$];
  sched_result_t due_results[$];
  sched_req_t    cur_req;
  int            idle_pct = 33;
  int            est_load;
  int            fail_count = 0;

  function automatic void enqueue_proc(int lvl, logic [7:0] id);
    run_queue[lvl][q_tail[lvl]] = id;
    q_tail[lvl] = q_tail[lvl] + 4'd1;
    q_occ[lvl] = q_occ[lvl] + 5'd1;
  endfunction

  function automatic logic [7:0] dequeue_proc(int lvl);
    logic [7:0] id;
    id = run_queue[lvl][q_head[lvl]];
    q_head[lvl] = q_head[lvl] + 4'd1;
    q_occ[lvl] = q_occ[lvl] - 5'd1;
    return id;
  endfunction

  function automatic sched_result_t mk_res(mfq_pkg::kind_t kind, logic [7:0] pid,
                                           logic [3:0] level);
    sched_result_t r;
    r.kind = kind;
    r.pid = pid;
    r.level = level;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out every result that one accepted item causes and queues them.
  function automatic void schedule_item(sched_req_t req);
    sched_result_t batch[$];
    int nl;
    int top;
    int lv;
    bit found;
    logic [7:0] id;
    nl = (levels_reg == 0) ? 1 : (levels_reg > MAX_LV) ? MAX_LV : int'(levels_reg);
    top = nl - 1;
    if (req.func == mfq_pkg::FUNC_ADMIT) begin
      if (total_procs >= MAX_PR) begin
        batch.insert(batch.size(), mk_res(mfq_pkg::KIND_ERROR, req.pid, 4'd0));
      end else begin
        enqueue_proc(top, req.pid);
        total_procs = total_procs + 5'd1;
        batch.insert(batch.size(), mk_res(mfq_pkg::KIND_ADMIT, req.pid, 4'(nl)));
      end
    end else begin
      found = 1'b0;
      lv = 0;
      for (int i = top; i >= 0; i--) begin
        if (!found && q_occ[i] != 0) begin
          lv = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        batch.insert(batch.size(), mk_res(mfq_pkg::KIND_ERROR, 8'd0, 4'd0));
      end else if (req.oc == mfq_pkg::OUT_INVALID) begin
        batch.insert(batch.size(),
                     mk_res(mfq_pkg::KIND_ERROR, run_queue[lv][q_head[lv]], 4'd0));
      end else begin
        id = dequeue_proc(lv);
        case (req.oc)
          mfq_pkg::OUT_YIELD: begin
            enqueue_proc(lv, id);
            batch.insert(batch.size(), mk_res(mfq_pkg::KIND_YIELD, id, 4'(lv + 1)));
          end
          mfq_pkg::OUT_FULL: begin
            lv = (lv > 0) ? lv - 1 : 0;
            enqueue_proc(lv, id);
            batch.insert(batch.size(), mk_res(mfq_pkg::KIND_FULL, id, 4'(lv + 1)));
          end
          default: begin
            total_procs = total_procs - 5'd1;
            batch.insert(batch.size(), mk_res(mfq_pkg::KIND_EXIT, id, 4'd0));
          end
        endcase
        slices_since_boost = slices_since_boost + 16'd1;
        if (slices_since_boost == period_reg) begin
          slices_since_boost = '0;
          // Lower levels are walked from just below the top downward, each oldest first.
          for (int i = top; i > 0; i--) begin
            while (q_occ[i - 1] != 0 && batch.size() < 1 + MAX_PR) begin
              id = dequeue_proc(i - 1);
              enqueue_proc(top, id);
              batch.insert(batch.size(), mk_res(mfq_pkg::KIND_BOOST, id, 4'(nl)));
            end
          end
        end
      end
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) due_results.insert(due_results.size(), batch[k]);
  endfunction

  // Sender: prediction happens on the edge at which the transfer takes place.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) schedule_item(cur_req);
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(mfq_pkg::IN_TDATA_W - 10){1'b0}}, cur_req.oc, cur_req.pid};
          in_tuser <= cur_req.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and field-by-field comparison.
  always @(posedge clk) begin
    sched_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: kind %0d id %0d level %0d last %0b",
                   out_tuser, out_tdata[7:0], out_tdata[11:8], out_tlast);
      end else begin
        exp_res = due_results.pop_front();
        if (out_tuser != exp_res.kind || out_tdata[7:0] != exp_res.pid ||
            out_tdata[11:8] != exp_res.level || out_tlast != exp_res.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: expected kind %0d id %0d level %0d last %0b, ",
                      "got kind %0d id %0d level %0d last %0b"},
                     exp_res.kind, exp_res.pid, exp_res.level, exp_res.last,
                     out_tuser, out_tdata[7:0], out_tdata[11:8], out_tlast);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic add_req(logic func, logic [7:0] pid, mfq_pkg::outcome_t oc);
    sched_req_t r;
    r.func = func;
    r.pid = pid;
    r.oc = oc;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Keeps a rough count of stored processes so the mix stays near a busy, not full, store.
  task automatic add_random_reqs(int count);
    int pct;
    int w;
    sched_req_t r;
    est_load = total_procs;
    repeat (count) begin
      pct = (est_load < 4) ? 75 : (est_load > 12) ? 20 : 40;
      r.func = ($urandom_range(99) < pct) ? mfq_pkg::FUNC_ADMIT : mfq_pkg::FUNC_SLICE;
      r.pid = 8'($urandom);
      w = $urandom_range(99);
      r.oc = (w < 35) ? mfq_pkg::OUT_YIELD :
             (w < 65) ? mfq_pkg::OUT_FULL :
             (w < 90) ? mfq_pkg::OUT_FINISH : mfq_pkg::OUT_INVALID;
      if (r.func == mfq_pkg::FUNC_ADMIT) begin
        if (est_load < MAX_PR) est_load++;
      end else if (r.oc == mfq_pkg::OUT_FINISH && est_load > 0) begin
        est_load--;
      end
      pending_reqs.insert(pending_reqs.size(), r);
    end
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [mfq_pkg::CFG_IDX_W-1:0] idx,
                           logic [mfq_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == mfq_pkg::CFG_NUM_LEVELS) levels_reg = data[3:0];
    else period_reg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] lv_word, logic [15:0] period, int idle, int count);
    drain_all();
    write_reg(mfq_pkg::CFG_NUM_LEVELS, lv_word);
    write_reg(mfq_pkg::CFG_BOOST_PERIOD, period);
    idle_pct = idle;
    add_random_reqs(count);
  endtask

  initial begin
    foreach (q_head[i]) begin
      q_head[i] = '0;
      q_tail[i] = '0;
      q_occ[i] = '0;
    end
    total_procs = '0;
    slices_since_boost = '0;
    levels_reg = mfq_pkg::NUM_LEVELS_RST;
    period_reg = mfq_pkg::BOOST_PERIOD_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty slice, fill the store to overflow, then each outcome.
    add_req(mfq_pkg::FUNC_SLICE, 8'h3C, mfq_pkg::OUT_YIELD);
    add_req(mfq_pkg::FUNC_ADMIT, 8'h00, mfq_pkg::OUT_INVALID);
    add_req(mfq_pkg::FUNC_ADMIT, 8'hFF, mfq_pkg::OUT_YIELD);
    repeat (14) add_req(mfq_pkg::FUNC_ADMIT, 8'($urandom),
                        mfq_pkg::outcome_t'(2'($urandom)));
    add_req(mfq_pkg::FUNC_ADMIT, 8'hC3, mfq_pkg::OUT_FINISH);
    add_req(mfq_pkg::FUNC_SLICE, 8'hFF, mfq_pkg::OUT_INVALID);
    add_req(mfq_pkg::FUNC_SLICE, 8'h00, mfq_pkg::OUT_YIELD);
    add_req(mfq_pkg::FUNC_SLICE, 8'hAA, mfq_pkg::OUT_FULL);
    add_req(mfq_pkg::FUNC_SLICE, 8'h55, mfq_pkg::OUT_FULL);
    add_req(mfq_pkg::FUNC_SLICE, 8'h0F, mfq_pkg::OUT_FINISH);
    add_req(mfq_pkg::FUNC_SLICE, 8'hF0, mfq_pkg::OUT_FINISH);

    // Lowering the level count strands the processes parked in the upper levels.
    run_phase(16'hA5F2, 16'd1, 33, 20);
    run_phase(16'd8, 16'd3, 33, 20);
    run_phase(16'd0, 16'd5, 33, 20);
    run_phase(16'd15, 16'hFFFF, 0, 20);
    run_phase(16'd1, 16'd2, 33, 20);
    run_phase(16'd6, 16'd0, 33, 18);
    run_phase(16'd4, 16'd8, 33, 18);

    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (40) @(negedge clk);
    if (due_results.size() != 0) begin
      fail_count++;
      $display("%0d results never delivered", due_results.size());
    end
    if (fail_count == 0) begin
      $display("** multilevel_feedback_queue_scheduler_unit: PASSED **");
    end else begin
      $display("** multilevel_feedback_queue_scheduler_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** multilevel_feedback_queue_scheduler_unit: FAILED **");
    $finish;
  end

endmodule
